@@ hw/rtl/fbpa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_pkg
// shared types, sizes and codes of the fixed block pool allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int MAX_BLOCKS  = 256;
    // block size must be a power of two, offsets split by shift and mask
    localparam int BLOCK_BYTES = 2048;
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);

    localparam int ADDR_W      = 32;
    localparam int CNT_W       = 9;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;

    // used map is kept as words of a bitmap memory
    localparam int WORD_BITS   = 32;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int WORDS       = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_IDX_W  = (WORDS > 1) ? $clog2(WORDS) : 1;

    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic [OP_W-1:0] OP_ALLOC     = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE   = 2'd1;
    localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_SIZE    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BADADDR = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_DOUBLE  = 3'd4;

    localparam logic [1:0] REG_POOL_START    = 2'd0;
    localparam logic [1:0] REG_BLOCK_COUNT   = 2'd1;
    localparam logic [1:0] REG_LOCAL_BASE    = 2'd2;
    localparam logic [1:0] REG_PHYSICAL_BASE = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/fbpa_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_req_if
// request channel: operation, size and address with valid/ready
// ----------------------------------------------------------------------------
interface fbpa_req_if;
    logic                         valid;
    logic                         ready;
    logic [fbpa_pkg::OP_W-1:0]    operation;
    logic [fbpa_pkg::ADDR_W-1:0]  request_size;
    logic [fbpa_pkg::ADDR_W-1:0]  block_address;

    modport source (output valid, output operation, output request_size,
                    output block_address, input ready);
    modport sink   (input valid, input operation, input request_size,
                    input block_address, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fbpa_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_rsp_if
// result channel: status, address and used count with valid/ready
// ----------------------------------------------------------------------------
interface fbpa_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [fbpa_pkg::STATUS_W-1:0]  status;
    logic [fbpa_pkg::ADDR_W-1:0]    result_address;
    logic [fbpa_pkg::CNT_W-1:0]     used_blocks;

    modport source (output valid, output status, output result_address,
                    output used_blocks, input ready);
    modport sink   (input valid, input status, input result_address,
                    input used_blocks, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fixed_block_pool_allocator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit
// first-fit allocator over a pool of equal blocks, with release and
// local-to-physical address translation
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  req       in         valid/ready      operation, request_size, block_address
//  rsp       out        valid/ready      status, result_address, used_blocks
//  apb       in         psel/penable     pool_start, block_count, local_base,
//                                        physical_base
//
//  each request goes through accept, bitmap word read, evaluate and write
//  back in turn, as the single-port bitmap memory needs a read-modify-write.
//  a per-word full flag picks the word holding the lowest free block.
//  reset clears per-word valid bits at once, so no clearing pass is needed.
//  a new request is taken while a result waits; evaluation stalls until the
//  output register is free.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fbpa_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [fbpa_pkg::PDATA_W-1:0]  pwdata,
    output logic      [fbpa_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    fbpa_req_if.sink                           req,
    fbpa_rsp_if.source                         rsp
);

    localparam int AW = fbpa_pkg::ADDR_W;
    localparam int CW = fbpa_pkg::CNT_W;
    localparam int WB = fbpa_pkg::WORD_BITS;
    localparam int WN = fbpa_pkg::WORDS;
    localparam int WI = fbpa_pkg::WORD_IDX_W;
    localparam int BW = fbpa_pkg::BIT_W;

    // configuration
    logic [AW-1:0] pool_start_reg;
    logic [CW-1:0] block_count_reg;
    logic [AW-1:0] local_base_reg;
    logic [AW-1:0] physical_base_reg;
    logic [CW-1:0] count_eff;

    // control
    fbpa_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    used_reg, used_next;
    logic [WN-1:0]    word_valid_reg;
    logic [WN-1:0]    word_full_reg;
    logic             rsp_valid_reg;

    // latched request
    logic [fbpa_pkg::OP_W-1:0] op_reg;
    logic [AW-1:0]             size_reg;
    logic [AW-1:0]             addr_reg;

    // bitmap memory
    logic [WB-1:0] bitmap_mem [WN];
    logic [WB-1:0] rd_data_reg;
    logic          rd_valid_reg;
    logic [WI-1:0] word_sel_reg;
    logic [BW-1:0] bit_sel_reg;
    logic          bad_reg;
    logic          nofree_reg;

    // read-stage signals
    logic [AW-1:0] offset;
    logic [AW-1:0] rel_idx;
    logic          rel_bad;
    logic [WI-1:0] free_word;
    logic          free_found;
    logic [WI-1:0] rd_word;

    // evaluate-stage signals
    logic [WB-1:0]              cur_word;
    logic [BW-1:0]              zero_bit;
    logic                       zero_found;
    logic [WI+BW-1:0]           alloc_blk;
    logic [fbpa_pkg::STATUS_W-1:0] ev_status;
    logic [AW-1:0]              ev_result;
    logic                       wr_en;
    logic [WB-1:0]              wr_data;

    logic accept;
    logic eval_go;
    logic cfg_wr;

    // result registers
    logic [fbpa_pkg::STATUS_W-1:0] status_reg;
    logic [AW-1:0]                 result_reg;
    logic [CW-1:0]                 used_out_reg;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_start_reg    <= '0;
            block_count_reg   <= '0;
            local_base_reg    <= '0;
            physical_base_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                fbpa_pkg::REG_POOL_START:    pool_start_reg    <= pwdata;
                fbpa_pkg::REG_BLOCK_COUNT:   block_count_reg   <= pwdata[CW-1:0];
                fbpa_pkg::REG_LOCAL_BASE:    local_base_reg    <= pwdata;
                fbpa_pkg::REG_PHYSICAL_BASE: physical_base_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            fbpa_pkg::REG_POOL_START:    prdata = pool_start_reg;
            fbpa_pkg::REG_BLOCK_COUNT:   prdata = 32'(block_count_reg);
            fbpa_pkg::REG_LOCAL_BASE:    prdata = local_base_reg;
            fbpa_pkg::REG_PHYSICAL_BASE: prdata = physical_base_reg;
            default:                     prdata = '0;
        endcase
    end

    assign count_eff = (32'(block_count_reg) > 32'(fbpa_pkg::MAX_BLOCKS))
                       ? CW'(fbpa_pkg::MAX_BLOCKS) : block_count_reg;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign eval_go = !rsp_valid_reg || rsp.ready;
    assign accept  = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fbpa_pkg::ST_IDLE: if (req.valid) state_next = fbpa_pkg::ST_READ;
            fbpa_pkg::ST_READ: state_next = fbpa_pkg::ST_EVAL;
            fbpa_pkg::ST_EVAL: if (eval_go) state_next = fbpa_pkg::ST_IDLE;
            default:           state_next = fbpa_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        case (state_reg)
            fbpa_pkg::ST_IDLE: req.ready = 1'b1;
            default:           req.ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fbpa_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.operation;
            size_reg <= req.request_size;
            addr_reg <= req.block_address;
        end
    end

    // ------------------------------------------------------------------
    // read stage: pick the bitmap word
    // ------------------------------------------------------------------
    assign offset  = addr_reg - pool_start_reg;
    assign rel_idx = offset >> fbpa_pkg::BLOCK_SHIFT;
    assign rel_bad = ((offset & AW'(fbpa_pkg::BLOCK_BYTES - 1)) != '0)
                     || (rel_idx >= 32'(count_eff));

    // lowest word that still has a free bit
    always_comb
    begin
        free_word  = '0;
        free_found = 1'b0;
        for (int i = WN - 1; i >= 0; i--)
        begin
            if (!word_full_reg[i])
            begin
                free_word  = WI'(i);
                free_found = 1'b1;
            end
        end
    end

    assign rd_word = (op_reg == fbpa_pkg::OP_ALLOC) ? free_word : rel_idx[WI+BW-1:BW];

    always_ff @(posedge clk)
    begin
        if (state_reg == fbpa_pkg::ST_READ)
        begin
            rd_data_reg  <= bitmap_mem[rd_word];
            rd_valid_reg <= word_valid_reg[rd_word];
            word_sel_reg <= rd_word;
            bit_sel_reg  <= rel_idx[BW-1:0];
            bad_reg      <= rel_bad;
            nofree_reg   <= !free_found;
        end
        if (wr_en)
            bitmap_mem[word_sel_reg] <= wr_data;
    end

    // ------------------------------------------------------------------
    // evaluate stage: modify the word and form the result
    // ------------------------------------------------------------------
    assign cur_word = rd_valid_reg ? rd_data_reg : '0;

    always_comb
    begin
        zero_bit   = '0;
        zero_found = 1'b0;
        for (int b = WB - 1; b >= 0; b--)
        begin
            if (!cur_word[b])
            begin
                zero_bit   = BW'(b);
                zero_found = 1'b1;
            end
        end
    end

    assign alloc_blk = {word_sel_reg, zero_bit};

    always_comb
    begin
        ev_status = fbpa_pkg::STATUS_OK;
        ev_result = '0;
        used_next = used_reg;
        wr_data   = cur_word;
        wr_en     = 1'b0;
        case (op_reg)
            fbpa_pkg::OP_ALLOC:
            begin
                if (32'(used_reg) >= 32'(count_eff))
                    ev_status = fbpa_pkg::STATUS_FULL;
                else if (size_reg > AW'(fbpa_pkg::BLOCK_BYTES))
                    ev_status = fbpa_pkg::STATUS_SIZE;
                else if (nofree_reg || !zero_found
                         || 32'(alloc_blk) >= 32'(count_eff))
                    ev_status = fbpa_pkg::STATUS_FULL;
                else
                begin
                    wr_data[zero_bit] = 1'b1;
                    wr_en     = 1'b1;
                    used_next = used_reg + CW'(1);
                    ev_result = pool_start_reg
                                + (32'(alloc_blk) << fbpa_pkg::BLOCK_SHIFT);
                end
            end
            fbpa_pkg::OP_RELEASE:
            begin
                if (bad_reg)
                    ev_status = fbpa_pkg::STATUS_BADADDR;
                else if (!cur_word[bit_sel_reg])
                    ev_status = fbpa_pkg::STATUS_DOUBLE;
                else
                begin
                    wr_data[bit_sel_reg] = 1'b0;
                    wr_en = 1'b1;
                    if (used_reg != '0)
                        used_next = used_reg - CW'(1);
                end
            end
            fbpa_pkg::OP_TRANSLATE:
                ev_result = addr_reg - local_base_reg + physical_base_reg;
            default:
                ev_status = fbpa_pkg::STATUS_BADADDR;
        endcase
        // only commit when the result register can take the result
        if (!(state_reg == fbpa_pkg::ST_EVAL && eval_go))
        begin
            wr_en     = 1'b0;
            used_next = used_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            word_valid_reg <= '0;
            word_full_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            if (wr_en)
            begin
                word_valid_reg[word_sel_reg] <= 1'b1;
                word_full_reg[word_sel_reg]  <= &wr_data;
            end
            if (state_reg == fbpa_pkg::ST_EVAL && eval_go)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == fbpa_pkg::ST_EVAL && eval_go)
        begin
            status_reg   <= ev_status;
            result_reg   <= ev_result;
            used_out_reg <= used_next;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.result_address = result_reg;
    assign rsp.used_blocks    = used_out_reg;

endmodule
`default_nettype wire

@@ verif/tb_fixed_block_pool_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator_unit
// self-checking bench for the block pool allocator: requests go in on the
// request channel, a local model of the used map predicts every result and
// the monitor compares each one in order. pool settings change between
// phases through the apb port; random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator_unit;

    localparam logic [fbpa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        logic [fbpa_pkg::STATUS_W-1:0] status;
        logic [fbpa_pkg::ADDR_W-1:0]   result_address;
        logic [fbpa_pkg::CNT_W-1:0]    used_blocks;
    } pool_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [fbpa_pkg::PADDR_W-1:0] paddr;
    logic [fbpa_pkg::PDATA_W-1:0] pwdata;
    logic [fbpa_pkg::PDATA_W-1:0] prdata;
    logic pready;

    fbpa_req_if req_ch ();
    fbpa_rsp_if rsp_ch ();

    fixed_block_pool_allocator_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    // shadow of the pool settings and of the used map
    logic [fbpa_pkg::ADDR_W-1:0] cfg_pool_start    = '0;
    logic [fbpa_pkg::CNT_W-1:0]  cfg_block_count   = '0;
    logic [fbpa_pkg::ADDR_W-1:0] cfg_local_base    = '0;
    logic [fbpa_pkg::ADDR_W-1:0] cfg_physical_base = '0;
    bit                          block_busy [fbpa_pkg::MAX_BLOCKS];
    int unsigned                 blocks_in_use = 0;
    int                          held_blocks [$];

    pool_result_t pending_results [$];

    int n_requests = 0;
    int n_results  = 0;
    int n_failures = 0;
    int n_settings = 0;
    int stall_cycles = 0;
    int rsp_hold_cycles = 0;
    bit req_idle_en = 1'b1;
    bit rsp_idle_en = 1'b1;

    always #5 clk = ~clk;

    function automatic int unsigned usable_blocks();
        return (int'(cfg_block_count) > fbpa_pkg::MAX_BLOCKS)
               ? fbpa_pkg::MAX_BLOCKS : int'(cfg_block_count);
    endfunction

    function automatic logic [fbpa_pkg::ADDR_W-1:0] block_addr(input int unsigned slot);
        return cfg_pool_start + fbpa_pkg::ADDR_W'(slot) * fbpa_pkg::ADDR_W'(fbpa_pkg::BLOCK_BYTES);
    endfunction

    function automatic pool_result_t predict_pool_request(
        input logic [fbpa_pkg::OP_W-1:0]   op,
        input logic [fbpa_pkg::ADDR_W-1:0] size,
        input logic [fbpa_pkg::ADDR_W-1:0] addr);
        pool_result_t r;
        int unsigned  usable;
        logic [fbpa_pkg::ADDR_W-1:0] offset;
        logic [fbpa_pkg::ADDR_W-1:0] idx;
        r.status = fbpa_pkg::STATUS_OK;
        r.result_address = '0;
        usable = usable_blocks();
        case (op)
            fbpa_pkg::OP_ALLOC:
            begin
                // full check comes before the size check
                if (blocks_in_use >= usable)
                    r.status = fbpa_pkg::STATUS_FULL;
                else if (size > fbpa_pkg::ADDR_W'(fbpa_pkg::BLOCK_BYTES))
                    r.status = fbpa_pkg::STATUS_SIZE;
                else
                begin
                    r.status = fbpa_pkg::STATUS_FULL;
                    for (int i = 0; i < usable; i++)
                    begin
                        if (!block_busy[i])
                        begin
                            block_busy[i] = 1'b1;
                            blocks_in_use++;
                            r.result_address = block_addr(i);
                            r.status = fbpa_pkg::STATUS_OK;
                            held_blocks.insert(held_blocks.size(), i);
                            break;
                        end
                    end
                end
            end
            fbpa_pkg::OP_RELEASE:
            begin
                offset = addr - cfg_pool_start;
                idx = offset >> fbpa_pkg::BLOCK_SHIFT;
                if (offset[fbpa_pkg::BLOCK_SHIFT-1:0] != '0 || idx >= usable)
                    r.status = fbpa_pkg::STATUS_BADADDR;
                else if (!block_busy[idx])
                    r.status = fbpa_pkg::STATUS_DOUBLE;
                else
                begin
                    block_busy[idx] = 1'b0;
                    if (blocks_in_use > 0)
                        blocks_in_use--;
                    for (int j = 0; j < held_blocks.size(); j++)
                    begin
                        if (held_blocks[j] == idx)
                        begin
                            held_blocks.delete(j);
                            break;
                        end
                    end
                end
            end
            fbpa_pkg::OP_TRANSLATE:
                r.result_address = addr - cfg_local_base + cfg_physical_base;
            default:
                r.status = fbpa_pkg::STATUS_BADADDR;
        endcase
        r.used_blocks = fbpa_pkg::CNT_W'(blocks_in_use);
        return r;
    endfunction

    task automatic send_request(input logic [fbpa_pkg::OP_W-1:0] op,
                                input logic [fbpa_pkg::ADDR_W-1:0] size,
                                input logic [fbpa_pkg::ADDR_W-1:0] addr);
        int gap;
        if (req_idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 10);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.operation     <= op;
        req_ch.request_size  <= size;
        req_ch.block_address <= addr;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.insert(pending_results.size(), predict_pool_request(op, size, addr));
        n_requests++;
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [fbpa_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= fbpa_pkg::PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            fbpa_pkg::REG_POOL_START:    cfg_pool_start    = value;
            fbpa_pkg::REG_BLOCK_COUNT:   cfg_block_count   = value[fbpa_pkg::CNT_W-1:0];
            fbpa_pkg::REG_LOCAL_BASE:    cfg_local_base    = value;
            fbpa_pkg::REG_PHYSICAL_BASE: cfg_physical_base = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure_pool(input logic [fbpa_pkg::ADDR_W-1:0] start,
                                  input logic [fbpa_pkg::CNT_W-1:0]  count,
                                  input logic [fbpa_pkg::ADDR_W-1:0] lbase,
                                  input logic [fbpa_pkg::ADDR_W-1:0] pbase);
        wait_idle();
        write_reg(fbpa_pkg::REG_POOL_START, start);
        write_reg(fbpa_pkg::REG_BLOCK_COUNT, fbpa_pkg::PDATA_W'(count));
        write_reg(fbpa_pkg::REG_LOCAL_BASE, lbase);
        write_reg(fbpa_pkg::REG_PHYSICAL_BASE, pbase);
        n_settings++;
    endtask

    task automatic run_mixed_traffic(input int n_items);
        int k;
        int roll;
        int slot;
        int unsigned usable;
        logic [fbpa_pkg::OP_W-1:0]   op;
        logic [fbpa_pkg::ADDR_W-1:0] size;
        logic [fbpa_pkg::ADDR_W-1:0] addr;
        for (k = 0; k < n_items; k++)
        begin
            usable = usable_blocks();
            op   = fbpa_pkg::OP_TRANSLATE;
            size = $urandom();
            addr = $urandom();
            roll = $urandom_range(0, 99);
            if (roll < 85)
            begin
                // mostly allocate for three quarters of the phase, then drain
                if ($urandom_range(0, 99) < ((k < n_items * 3 / 4) ? 88 : 15))
                begin
                    op = fbpa_pkg::OP_ALLOC;
                    case ($urandom_range(0, 3))
                        0: size = '0;
                        1: size = fbpa_pkg::ADDR_W'(fbpa_pkg::BLOCK_BYTES);
                        default: size = $urandom_range(0, fbpa_pkg::BLOCK_BYTES);
                    endcase
                end
                else if (held_blocks.size() != 0)
                begin
                    op = fbpa_pkg::OP_RELEASE;
                    slot = held_blocks[$urandom_range(0, held_blocks.size() - 1)];
                    addr = block_addr(slot);
                end
            end
            else if (roll >= 90)
            begin
                case ($urandom_range(0, 4))
                    0:
                    begin
                        op = fbpa_pkg::OP_ALLOC;
                        size = $urandom_range(fbpa_pkg::BLOCK_BYTES + 1, 32'hFFFF_FFFF);
                    end
                    1:
                    begin
                        // misaligned release
                        op = fbpa_pkg::OP_RELEASE;
                        addr = block_addr($urandom_range(0, usable))
                               + fbpa_pkg::ADDR_W'($urandom_range(1, fbpa_pkg::BLOCK_BYTES - 1));
                    end
                    2:
                    begin
                        // free, used or one past the end
                        op = fbpa_pkg::OP_RELEASE;
                        addr = block_addr($urandom_range(0, usable));
                    end
                    3: op = fbpa_pkg::OP_RELEASE;
                    default: op = OP_UNUSED;
                endcase
            end
            send_request(op, size, addr);
        end
    endtask

    task automatic test_reset_state();
        send_request(fbpa_pkg::OP_ALLOC, '0, $urandom());
        send_request(fbpa_pkg::OP_RELEASE, $urandom(), '0);
        send_request(fbpa_pkg::OP_TRANSLATE, $urandom(), 32'hFFFF_FFFF);
        send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_alloc_release_edges();
        // pool wraps past the top of the address space
        configure_pool(32'hFFFF_F000, 9'd3, 32'h8000_0000, 32'h0000_1000);
        send_request(fbpa_pkg::OP_ALLOC, '0, '0);
        send_request(fbpa_pkg::OP_ALLOC, fbpa_pkg::ADDR_W'(fbpa_pkg::BLOCK_BYTES + 1), '0);
        send_request(fbpa_pkg::OP_ALLOC, 32'hFFFF_FFFF, '0);
        send_request(fbpa_pkg::OP_ALLOC, fbpa_pkg::ADDR_W'(fbpa_pkg::BLOCK_BYTES), 32'hFFFF_FFFF);
        send_request(fbpa_pkg::OP_ALLOC, 32'd1, '0);
        send_request(fbpa_pkg::OP_ALLOC, fbpa_pkg::ADDR_W'(fbpa_pkg::BLOCK_BYTES + 1), '0);
        send_request(fbpa_pkg::OP_RELEASE, '0, 32'hFFFF_F800);
        send_request(fbpa_pkg::OP_RELEASE, '0, 32'hFFFF_F800);
        send_request(fbpa_pkg::OP_RELEASE, '0, 32'hFFFF_F801);
        send_request(fbpa_pkg::OP_RELEASE, '0, 32'h0000_0800);
        send_request(fbpa_pkg::OP_RELEASE, '0, 32'hFFFF_E800);
        send_request(fbpa_pkg::OP_ALLOC, 32'd100, '0);
        send_request(fbpa_pkg::OP_TRANSLATE, '0, '0);
        send_request(fbpa_pkg::OP_TRANSLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_UNUSED, '0, 32'hFFFF_F000);
    endtask

    task automatic test_pool_shrink();
        // blocks above the new count stay counted and cannot be released
        configure_pool(32'hFFFF_F000, 9'd1, 32'h8000_0000, 32'h0000_1000);
        send_request(fbpa_pkg::OP_RELEASE, '0, 32'h0000_0000);
        send_request(fbpa_pkg::OP_ALLOC, '0, '0);
        send_request(fbpa_pkg::OP_RELEASE, '0, 32'hFFFF_F000);
        send_request(fbpa_pkg::OP_ALLOC, '0, '0);
        // count above the pool size is clamped
        configure_pool(32'hFFFF_F000, 9'd511, 32'h8000_0000, 32'h0000_1000);
        send_request(fbpa_pkg::OP_ALLOC, '0, '0);
        send_request(fbpa_pkg::OP_ALLOC, '0, '0);
    endtask

    task automatic test_output_backpressure();
        configure_pool(32'h0001_0000, 9'd16, $urandom(), $urandom());
        req_idle_en = 1'b0;
        rsp_hold_cycles = HOLD_OFF_CYCLES;
        run_mixed_traffic(40);
        req_idle_en = 1'b1;
    endtask

    task automatic test_random_traffic();
        configure_pool($urandom(), 9'd8, $urandom(), $urandom());
        run_mixed_traffic(220);
        configure_pool('0, 9'd256, '0, 32'hFFFF_FFFF);
        run_mixed_traffic(560);
        configure_pool(32'hFFFF_FFFF, 9'd511, $urandom(), $urandom());
        run_mixed_traffic(200);
        configure_pool($urandom(), 9'd1, 32'hFFFF_FFFF, '0);
        run_mixed_traffic(150);
        configure_pool($urandom(), 9'd0, $urandom(), $urandom());
        run_mixed_traffic(60);
        // closing stretch at full rate on both sides
        req_idle_en = 1'b0;
        rsp_idle_en = 1'b0;
        configure_pool($urandom(), fbpa_pkg::CNT_W'($urandom_range(2, 40)), $urandom(),
                       $urandom());
        run_mixed_traffic(400);
    endtask

    initial
    begin
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.operation     <= '0;
        req_ch.request_size  <= '0;
        req_ch.block_address <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_alloc_release_edges();
        test_pool_shrink();
        test_output_backpressure();
        test_random_traffic();
        wait_idle();
        n_failures += pending_results.size();
        $display("%0d requests checked against %0d results over %0d pool settings", n_requests,
                 n_results, n_settings);
        $display("full, clamped, shrunk, empty and wrapping pools, stalled output, %0d failures",
                 n_failures);
        if (n_failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // result side ready, with random stalls and one long hold-off on request
    initial
    begin : rsp_driver
        int n;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (rsp_hold_cycles > 0)
            begin
                n = rsp_hold_cycles;
                rsp_hold_cycles = 0;
                rsp_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (rsp_idle_en && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 10);
                rsp_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : rsp_monitor
        pool_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                n_failures++;
                if (n_failures <= 10)
                    $display("unexpected result: status %0d addr %h used %0d", rsp_ch.status,
                             rsp_ch.result_address, rsp_ch.used_blocks);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status || rsp_ch.result_address !== want.result_address
                    || rsp_ch.used_blocks !== want.used_blocks)
                begin
                    n_failures++;
                    if (n_failures <= 10)
                        $display("result %0d: expected status %0d addr %h used %0d, got %0d %h %0d",
                                 n_results, want.status, want.result_address, want.used_blocks,
                                 rsp_ch.status, rsp_ch.result_address, rsp_ch.used_blocks);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         stall_cycles, pending_results.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
